[hdl/mcd_pkg.sv]
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types and character codes for the Morse trie decoder.
// ----------------------------------------------------------------------------
package mcd_pkg;

   localparam int CHAR_W   = 8;
   localparam int LOAD_LEN_W  = 4;
   localparam int LOAD_BITS_W = 9;
   localparam int EXT_W    = 16;

   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] letter;
   } entry_type;

   typedef struct packed {
      logic pending;
      logic overflowed;
      logic slash_only;
   } tok_flags_type;

endpackage

[hdl/mcd_table.sv]
// ----------------------------------------------------------------------------
// mcd_table
// Heap-indexed letter table: one write port, one registered read port, and a
// clearing sweep over every entry after reset.
// ----------------------------------------------------------------------------
module mcd_table #(
   parameter int ADDR_W = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  mcd_pkg::entry_type  wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output mcd_pkg::entry_type  rd_data,
   output logic                busy
);

   mcd_pkg::entry_type mem [0:(1 << ADDR_W)-1];
   mcd_pkg::entry_type rd_data_ff;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

[hdl/mcd_token.sv]
// ----------------------------------------------------------------------------
// mcd_token
// Collects the dot/dash path of the current token and forms its table index.
// ----------------------------------------------------------------------------
module mcd_token #(
   parameter int MAX_CODE_LEN = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          clear,
   input  logic [mcd_pkg::CHAR_W-1:0]    ch,
   output mcd_pkg::tok_flags_type        flags,
   output logic [MAX_CODE_LEN:0]         index
);

   localparam int LW = $clog2(MAX_CODE_LEN + 1);

   logic [MAX_CODE_LEN-1:0] path_bits_ff, path_bits_in;
   logic [LW-1:0]           path_len_ff, path_len_in;
   logic                    slash_only_ff, slash_only_in;
   logic                    overflowed_ff, overflowed_in;
   logic [MAX_CODE_LEN-1:0] mask;

   always_comb begin
      path_bits_in  = path_bits_ff;
      path_len_in   = path_len_ff;
      slash_only_in = slash_only_ff;
      overflowed_in = overflowed_ff;
      if (clear) begin
         path_bits_in  = '0;
         path_len_in   = '0;
         slash_only_in = 1'b0;
         overflowed_in = 1'b0;
      end else if (step) begin
         if (path_len_ff >= LW'(MAX_CODE_LEN)) begin
            overflowed_in = 1'b1;
            slash_only_in = 1'b0;
         end else begin
            slash_only_in = (path_len_ff == '0) && (ch == mcd_pkg::CH_SLASH);
            for (int i = 0; i < MAX_CODE_LEN; i++) begin
               if ((LW'(i) == path_len_ff) && (ch != mcd_pkg::CH_DOT)) begin
                  path_bits_in[i] = 1'b1;
               end
            end
            path_len_in = path_len_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         path_bits_ff  <= '0;
         path_len_ff   <= '0;
         slash_only_ff <= 1'b0;
         overflowed_ff <= 1'b0;
      end else begin
         path_bits_ff  <= path_bits_in;
         path_len_ff   <= path_len_in;
         slash_only_ff <= slash_only_in;
         overflowed_ff <= overflowed_in;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
         mask[i] = LW'(i) < path_len_ff;
      end
   end

   // node of depth L with bits b sits at (2^L - 1) + b
   assign index = {1'b0, mask} + {1'b0, path_bits_ff};

   assign flags.pending    = (path_len_ff != '0) || overflowed_ff;
   assign flags.overflowed = overflowed_ff;
   assign flags.slash_only = slash_only_ff;

endmodule

[hdl/morse_code_decoder.sv]
// ----------------------------------------------------------------------------
// morse_code_decoder
// Decodes Morse text against a loadable dot/dash trie held in one memory.
// Load and symbol beats give no result; a lookup result goes from its
// separator beat through ST_READ, ST_PUT and the output register, a slash or
// over-long result through ST_PUT and the output register, and an end-of-line
// result through ST_EOL after the letter before it.
// Throughput: 1 beat per cycle for loads and symbols while req_ready is high;
// a separator holds input until its result is out, after any rsp_ready wait.
// Reset: token state clears at once; req_ready is low while the table is swept.
// ----------------------------------------------------------------------------
module morse_code_decoder #(
   parameter int MAX_CODE_LEN = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_char_in,
   input  logic [3:0]  req_load_len,
   input  logic [8:0]  req_load_bits,
   input  logic [7:0]  req_load_letter,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_is_error,
   output logic        rsp_end_of_line,
   output logic        rsp_last
);

   localparam int AW = MAX_CODE_LEN + 1;

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_PUT  = 2'd2;
   localparam logic [1:0] ST_EOL  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept, is_sep, is_nl, step, clear, out_free;
   logic       busy;

   mcd_pkg::tok_flags_type tok_flags;
   logic [AW-1:0]          tok_index;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   mcd_pkg::entry_type     wr_data;
   mcd_pkg::entry_type     rd_data;
   logic [MAX_CODE_LEN-1:0] lmask, lbits;
   logic [mcd_pkg::EXT_W-1:0] lbits_ext;

   logic [7:0] res_char_ff, res_char_in;
   logic       res_err_ff, res_err_in;
   logic       eol_ff, eol_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_err_ff, rsp_err_in;
   logic       rsp_eol_ff, rsp_eol_in;
   logic       rsp_last_ff, rsp_last_in;

   assign req_ready = (state_ff == ST_RUN) && !busy;
   assign accept    = req_valid && req_ready;
   assign is_nl     = req_char_in == mcd_pkg::CH_NL;
   assign is_sep    = is_nl || (req_char_in == mcd_pkg::CH_SPACE);
   assign step      = accept && !req_mode && !is_sep;
   assign clear     = accept && !req_mode && is_sep;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   mcd_token #(
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_token (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .clear (clear),
      .ch    (req_char_in),
      .flags (tok_flags),
      .index (tok_index)
   );

   // load index: (2^len - 1) + (bits & mask)
   assign lbits_ext = mcd_pkg::EXT_W'(req_load_bits);
   always_comb begin
      for (int i = 0; i < MAX_CODE_LEN; i++) begin
         lmask[i] = 4'(i) < req_load_len;
         lbits[i] = lbits_ext[i] & lmask[i];
      end
   end

   assign wr_en          = accept && req_mode && (req_load_len <= 4'(MAX_CODE_LEN));
   assign wr_addr        = {1'b0, lmask} + {1'b0, lbits};
   assign wr_data.valid  = 1'b1;
   assign wr_data.letter = req_load_letter;

   mcd_table #(
      .ADDR_W(AW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (tok_index),
      .rd_data (rd_data),
      .busy    (busy)
   );

   always_comb begin
      state_in     = state_ff;
      res_char_in  = res_char_ff;
      res_err_in   = res_err_ff;
      eol_in       = eol_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_eol_in   = rsp_eol_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_RUN: begin
            if (clear) begin
               eol_in = is_nl;
               if (tok_flags.pending) begin
                  if (tok_flags.overflowed) begin
                     res_char_in = '0;
                     res_err_in  = 1'b1;
                     state_in    = ST_PUT;
                  end else if (tok_flags.slash_only) begin
                     res_char_in = mcd_pkg::CH_SPACE;
                     res_err_in  = 1'b0;
                     state_in    = ST_PUT;
                  end else begin
                     state_in = ST_READ;
                  end
               end else if (is_nl) begin
                  state_in = ST_EOL;
               end
            end
         end
         ST_READ: begin
            res_char_in = rd_data.valid ? rd_data.letter : '0;
            res_err_in  = !rd_data.valid;
            state_in    = ST_PUT;
         end
         ST_PUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = res_char_ff;
               rsp_err_in   = res_err_ff;
               rsp_eol_in   = 1'b0;
               rsp_last_in  = !eol_ff;
               state_in     = eol_ff ? ST_EOL : ST_RUN;
            end
         end
         ST_EOL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_err_in   = 1'b0;
               rsp_eol_in   = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_char_ff <= res_char_in;
      res_err_ff  <= res_err_in;
      eol_ff      <= eol_in;
      rsp_char_ff <= rsp_char_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_eol_ff  <= rsp_eol_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_char    = rsp_char_ff;
   assign rsp_is_error    = rsp_err_ff;
   assign rsp_end_of_line = rsp_eol_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
